[rtl/c3m_pkg.sv]
// c3m_pkg: shared types, constants and register codes of the 3x3 modulo-wrap filter.
// No dependencies; used by every file of the block.
`timescale 1ns / 1ps

package c3m_pkg;

	localparam int IMAGE_WIDTH  = 64;
	localparam int IMAGE_HEIGHT = 64;
	localparam int COL_W        = $clog2(IMAGE_WIDTH);
	localparam int ROW_W        = $clog2(IMAGE_HEIGHT);

	localparam int PIX_W  = 8;
	localparam int COEF_W = 24;
	localparam int MOD_W  = 9;
	localparam int PROD_W = 17;
	localparam int ROWS_W = 19;
	localparam int SUM_W  = 20;
	localparam int MAG_W  = 19;
	localparam int CNT_W  = $clog2(MAG_W + 1);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd3;

	localparam logic [COEF_W-1:0] COEF_TOP_RST = 24'hFFFFFF;
	localparam logic [COEF_W-1:0] COEF_MID_RST = 24'hFF08FF;
	localparam logic [COEF_W-1:0] COEF_BOT_RST = 24'hFFFFFF;
	localparam logic [MOD_W-1:0]  MODULUS_RST  = 9'd255;
	localparam logic [MOD_W-1:0]  MODULUS_MAX  = 9'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_WAIT_MOD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] sum;
		logic [MOD_W-1:0]        modulus;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] rem;
	} mod_rsp_t;

endpackage

[rtl/c3m_mod_unit.sv]
// c3m_mod_unit: iterative non-negative remainder of a signed window sum, one bit a cycle.
// Depends on c3m_pkg.
`timescale 1ns / 1ps

module c3m_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  c3m_pkg::mod_req_t req,
	output c3m_pkg::mod_rsp_t rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic                        neg_q;
	logic [c3m_pkg::MAG_W-1:0]   mag_q;
	logic [c3m_pkg::MOD_W-1:0]   rem_q;
	logic [c3m_pkg::MOD_W-1:0]   m_q;
	logic [c3m_pkg::CNT_W-1:0]   cnt_q;
	logic [c3m_pkg::PIX_W-1:0]   res_q;

	logic [c3m_pkg::SUM_W-1:0]   abs_sum;
	logic [c3m_pkg::MOD_W-1:0]   m_clamp;
	logic [c3m_pkg::MOD_W:0]     shifted;
	logic [c3m_pkg::MOD_W:0]     diff;
	logic [c3m_pkg::MOD_W-1:0]   rem_next;
	logic [c3m_pkg::MOD_W-1:0]   fixed;

	always_comb begin
		abs_sum = req.sum[c3m_pkg::SUM_W-1] ? (~req.sum + 1'b1) : req.sum;
		if (req.modulus == '0) begin
			m_clamp = c3m_pkg::MOD_W'(1);
		end else if (req.modulus > c3m_pkg::MODULUS_MAX) begin
			m_clamp = c3m_pkg::MODULUS_MAX;
		end else begin
			m_clamp = req.modulus;
		end
		shifted  = {rem_q, mag_q[c3m_pkg::MAG_W-1]};
		diff     = shifted - {1'b0, m_q};
		rem_next = (shifted >= {1'b0, m_q}) ? diff[c3m_pkg::MOD_W-1:0]
		                                    : shifted[c3m_pkg::MOD_W-1:0];
		fixed    = (neg_q && rem_q != '0) ? (m_q - rem_q) : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= c3m_pkg::CNT_W'(c3m_pkg::MAG_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.sum[c3m_pkg::SUM_W-1];
			mag_q <= abs_sum[c3m_pkg::MAG_W-1:0];
			m_q   <= m_clamp;
			rem_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= rem_next;
				mag_q <= {mag_q[c3m_pkg::MAG_W-2:0], 1'b0};
			end else begin
				res_q <= fixed[c3m_pkg::PIX_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = res_q;

endmodule

[rtl/conv3x3_modulo_wrap.sv]
// conv3x3_modulo_wrap: 3x3 filter over a raster pixel stream, sum wrapped by a modulus.
// Depends on c3m_pkg and c3m_mod_unit.
// Flow: an accepted pixel is registered and shifts the window and line stores (ST_READ); a
// window pixel then passes the row MAC (ST_MAC), the bit-serial remainder (19 steps) and the
// output register; a new pixel is taken only once the last is through; output stalls hold it.
// Reset: control, counters and config clear at once; stores and data registers keep contents.
`timescale 1ns / 1ps

module conv3x3_modulo_wrap (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [c3m_pkg::PIX_W-1:0]        pixel,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [c3m_pkg::PIX_W-1:0]        filtered,
	output logic                             frame_last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [c3m_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [c3m_pkg::CFG_DAT_W-1:0]    cfg_data
);

	c3m_pkg::state_t st_q, st_d;

	logic [c3m_pkg::COEF_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [c3m_pkg::MOD_W-1:0]  modulus_q;

	logic [c3m_pkg::PIX_W-1:0] line_top_mem [c3m_pkg::IMAGE_WIDTH];
	logic [c3m_pkg::PIX_W-1:0] line_mid_mem [c3m_pkg::IMAGE_WIDTH];

	logic [c3m_pkg::COL_W-1:0] col_q;
	logic [c3m_pkg::ROW_W-1:0] row_q;

	logic [c3m_pkg::PIX_W-1:0] pix_s1, top_rd_s1, mid_rd_s1;
	logic [c3m_pkg::COL_W-1:0] col_s1;
	logic [c3m_pkg::ROW_W-1:0] row_s1;

	logic [c3m_pkg::PIX_W-1:0] win_q [6];
	logic [c3m_pkg::PIX_W-1:0] op_q [3][3];
	logic                      last_q;
	logic [1:0]                k_q;
	logic signed [c3m_pkg::SUM_W-1:0] acc_q, acc_d;

	logic [c3m_pkg::COEF_W-1:0]         crow;
	logic signed [c3m_pkg::PROD_W-1:0]  prod [3];
	logic signed [c3m_pkg::ROWS_W-1:0]  row_sum;

	logic                      out_valid_q;
	logic [c3m_pkg::PIX_W-1:0] filtered_q;
	logic                      frame_last_q;

	logic in_acc, produce, load_out;

	c3m_pkg::mod_req_t mod_req;
	c3m_pkg::mod_rsp_t mod_rsp;

	assign in_acc    = in_valid && !in_stall;
	assign produce   = (row_s1 >= c3m_pkg::ROW_W'(2)) && (col_s1 >= c3m_pkg::COL_W'(2));
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= c3m_pkg::COEF_TOP_RST;
			coef_mid_q <= c3m_pkg::COEF_MID_RST;
			coef_bot_q <= c3m_pkg::COEF_BOT_RST;
			modulus_q  <= c3m_pkg::MODULUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				c3m_pkg::REG_COEF_TOP: coef_top_q <= cfg_data;
				c3m_pkg::REG_COEF_MID: coef_mid_q <= cfg_data;
				c3m_pkg::REG_COEF_BOT: coef_bot_q <= cfg_data;
				c3m_pkg::REG_MODULUS:  modulus_q  <= cfg_data[c3m_pkg::MOD_W-1:0];
				default: ;
			endcase
		end
	end

	// raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_q == c3m_pkg::COL_W'(c3m_pkg::IMAGE_WIDTH - 1)) begin
				col_q <= '0;
				if (row_q == c3m_pkg::ROW_W'(c3m_pkg::IMAGE_HEIGHT - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// line stores: read on accept, write back in the following cycle (ST_READ)
	always_ff @(posedge clk) begin
		if (in_acc) begin
			top_rd_s1 <= line_top_mem[col_q];
		end
		if (st_q == c3m_pkg::ST_READ) begin
			line_top_mem[col_s1] <= mid_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mid_rd_s1 <= line_mid_mem[col_q];
		end
		if (st_q == c3m_pkg::ST_READ) begin
			line_mid_mem[col_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= pixel;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	// window columns and MAC operands
	always_ff @(posedge clk) begin
		if (st_q == c3m_pkg::ST_READ) begin
			op_q[0][0] <= win_q[0];
			op_q[0][1] <= win_q[3];
			op_q[0][2] <= top_rd_s1;
			op_q[1][0] <= win_q[1];
			op_q[1][1] <= win_q[4];
			op_q[1][2] <= mid_rd_s1;
			op_q[2][0] <= win_q[2];
			op_q[2][1] <= win_q[5];
			op_q[2][2] <= pix_s1;
			last_q     <= (row_s1 == c3m_pkg::ROW_W'(c3m_pkg::IMAGE_HEIGHT - 1)) &&
			              (col_s1 == c3m_pkg::COL_W'(c3m_pkg::IMAGE_WIDTH - 1));
			win_q[0]   <= win_q[3];
			win_q[1]   <= win_q[4];
			win_q[2]   <= win_q[5];
			win_q[3]   <= top_rd_s1;
			win_q[4]   <= mid_rd_s1;
			win_q[5]   <= pix_s1;
		end
	end

	// one kernel row per cycle
	always_comb begin
		case (k_q)
			2'd0:    crow = coef_top_q;
			2'd1:    crow = coef_mid_q;
			default: crow = coef_bot_q;
		endcase
		for (int j = 0; j < 3; j++) begin
			prod[j] = $signed(crow[8*j +: 8]) * $signed({1'b0, op_q[k_q][j]});
		end
		row_sum = {{2{prod[0][c3m_pkg::PROD_W-1]}}, prod[0]}
		        + {{2{prod[1][c3m_pkg::PROD_W-1]}}, prod[1]}
		        + {{2{prod[2][c3m_pkg::PROD_W-1]}}, prod[2]};
		acc_d   = acc_q + {{(c3m_pkg::SUM_W - c3m_pkg::ROWS_W){row_sum[c3m_pkg::ROWS_W-1]}},
		                   row_sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (st_q == c3m_pkg::ST_READ) begin
			k_q <= '0;
		end else if (st_q == c3m_pkg::ST_MAC && k_q != 2'd2) begin
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == c3m_pkg::ST_READ) begin
			acc_q <= '0;
		end else if (st_q == c3m_pkg::ST_MAC) begin
			acc_q <= acc_d;
		end
	end

	assign mod_req.start   = (st_q == c3m_pkg::ST_MAC) && (k_q == 2'd2);
	assign mod_req.sum     = acc_d;
	assign mod_req.modulus = modulus_q;

	c3m_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= c3m_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		in_stall = 1'b1;
		load_out = 1'b0;
		case (st_q)
			c3m_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					st_d = c3m_pkg::ST_READ;
				end
			end
			c3m_pkg::ST_READ: begin
				st_d = produce ? c3m_pkg::ST_MAC : c3m_pkg::ST_IDLE;
			end
			c3m_pkg::ST_MAC: begin
				if (k_q == 2'd2) begin
					st_d = c3m_pkg::ST_WAIT_MOD;
				end
			end
			c3m_pkg::ST_WAIT_MOD: begin
				if (mod_rsp.done) begin
					st_d = c3m_pkg::ST_DONE;
				end
			end
			c3m_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					st_d     = c3m_pkg::ST_IDLE;
				end
			end
			default: st_d = c3m_pkg::ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			filtered_q   <= mod_rsp.rem;
			frame_last_q <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign filtered   = filtered_q;
	assign frame_last = frame_last_q;

endmodule

[rtl/c3m_checker.sv]
// c3m_checker: port-level assertions for conv3x3_modulo_wrap, bound to the top level.
// Depends on c3m_pkg and conv3x3_modulo_wrap.
`timescale 1ns / 1ps

module c3m_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [c3m_pkg::PIX_W-1:0]        filtered,
	input logic                             frame_last
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered) && $stable(frame_last))
		else $error("result changed while stalled");

	// one request in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while previous still in work");

	// a new result only follows a busy period of the core
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall) && $past(in_stall, 2))
		else $error("result appeared without work");

endmodule

bind conv3x3_modulo_wrap c3m_checker u_c3m_checker (.*);

[sim/tb_top.sv]
// tb_top: self-checking bench for conv3x3_modulo_wrap, a directed table of fill spans
// followed by random kernel settings over the rest of the run.
// Depends on c3m_pkg and the block's RTL; a window filter inside the bench predicts results.
`timescale 1ns / 1ps

module tb_top;

	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int TOTAL_PIXELS  = 900;
	localparam int NO_FIXED      = -1;
	localparam int SPAN_COUNT    = 13;

	typedef struct packed {
		logic [c3m_pkg::PIX_W-1:0] filtered;
		logic                      frame_last;
	} wrapped_px_t;

	typedef struct packed {
		logic                       write_cfg;
		logic [c3m_pkg::COEF_W-1:0] top;
		logic [c3m_pkg::COEF_W-1:0] mid;
		logic [c3m_pkg::COEF_W-1:0] bot;
		logic [c3m_pkg::MOD_W-1:0]  modulus;
		logic [c3m_pkg::PIX_W-1:0]  fill;
		int                         count;
		int                         fixed_out;
	} fill_span_t;

	// constant fills; fixed_out only where the whole window lies in one fill
	fill_span_t fill_spans [SPAN_COUNT] = '{
		'{1'b0, c3m_pkg::COEF_TOP_RST, c3m_pkg::COEF_MID_RST, c3m_pkg::COEF_BOT_RST,
			c3m_pkg::MODULUS_RST, 8'd0, 192, 0},
		'{1'b0, c3m_pkg::COEF_TOP_RST, c3m_pkg::COEF_MID_RST, c3m_pkg::COEF_BOT_RST,
			c3m_pkg::MODULUS_RST, 8'd255, 128, NO_FIXED},
		'{1'b0, c3m_pkg::COEF_TOP_RST, c3m_pkg::COEF_MID_RST, c3m_pkg::COEF_BOT_RST,
			c3m_pkg::MODULUS_RST, 8'd255, 64, 0},
		'{1'b1, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 9'd256, 8'd255, 20, 137},
		'{1'b1, 24'h808080, 24'h808080, 24'h808080, 9'd256, 8'd255, 20, 128},
		'{1'b1, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 9'd0, 8'd255, 10, 0},
		'{1'b1, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 9'd1, 8'd255, 10, 0},
		'{1'b1, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 9'd511, 8'd255, 10, 137},
		'{1'b1, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 9'd7, 8'd255, 10, 6},
		'{1'b1, 24'h000000, 24'h000000, 24'h000000, 9'd256, 8'd255, 10, 0},
		'{1'b1, 24'h808080, 24'h808080, 24'h808080, 9'd256, 8'd0, 130, NO_FIXED},
		'{1'b1, 24'h808080, 24'h808080, 24'h808080, 9'd255, 8'd0, 20, 0},
		'{1'b1, 24'h01FF80, 24'h7F0080, 24'h80017F, 9'd200, 8'd1, 40, NO_FIXED}
	};

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic [c3m_pkg::PIX_W-1:0]     pixel     = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [c3m_pkg::PIX_W-1:0]     filtered;
	logic                          frame_last;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [c3m_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [c3m_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

	logic [c3m_pkg::PIX_W-1:0]  line_mem [2*c3m_pkg::IMAGE_WIDTH];
	logic [c3m_pkg::PIX_W-1:0]  win_mem [6];
	int                         pos_col = 0;
	int                         pos_row = 0;
	logic [c3m_pkg::COEF_W-1:0] k_top = c3m_pkg::COEF_TOP_RST;
	logic [c3m_pkg::COEF_W-1:0] k_mid = c3m_pkg::COEF_MID_RST;
	logic [c3m_pkg::COEF_W-1:0] k_bot = c3m_pkg::COEF_BOT_RST;
	logic [c3m_pkg::MOD_W-1:0]  k_mod = c3m_pkg::MODULUS_RST;

	wrapped_px_t wrapped_due [$];
	int          mismatches   = 0;
	int          results_seen = 0;
	int          pixels_sent  = 0;
	int          frame_ends   = 0;
	int          cfg_phases   = 0;
	int          quiet_cycles = 0;
	bit          lazy_sides   = 1'b1;

	conv3x3_modulo_wrap i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.filtered   (filtered),
		.frame_last (frame_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int kernel_row(input logic [c3m_pkg::COEF_W-1:0] k,
			input logic [c3m_pkg::PIX_W-1:0] a, input logic [c3m_pkg::PIX_W-1:0] b,
			input logic [c3m_pkg::PIX_W-1:0] c);
		int w0, w1, w2, pa, pb, pc;
		w0 = $signed(k[7:0]);
		w1 = $signed(k[15:8]);
		w2 = $signed(k[23:16]);
		pa = a;
		pb = b;
		pc = c;
		return w0 * pa + w1 * pb + w2 * pc;
	endfunction

	function automatic void filter_pixel(input logic [c3m_pkg::PIX_W-1:0] p,
			input int fixed_out);
		int                        m, s, rem;
		logic [c3m_pkg::PIX_W-1:0] up2, up1;
		wrapped_px_t               w;
		up2 = line_mem[pos_col];
		up1 = line_mem[c3m_pkg::IMAGE_WIDTH + pos_col];
		if (pos_row >= 2 && pos_col >= 2) begin
			m = k_mod;
			if (m == 0)
				m = 1;
			if (m > 256)
				m = 256;
			s = kernel_row(k_top, win_mem[0], win_mem[3], up2)
			  + kernel_row(k_mid, win_mem[1], win_mem[4], up1)
			  + kernel_row(k_bot, win_mem[2], win_mem[5], p);
			rem = s % m;
			if (rem < 0)
				rem += m;
			w.filtered   = (fixed_out != NO_FIXED) ? c3m_pkg::PIX_W'(fixed_out)
			                                       : c3m_pkg::PIX_W'(rem);
			w.frame_last = (pos_row == c3m_pkg::IMAGE_HEIGHT - 1 &&
			                pos_col == c3m_pkg::IMAGE_WIDTH - 1);
			if (w.frame_last)
				frame_ends++;
			wrapped_due.push_back(w);
		end
		win_mem[0] = win_mem[3];
		win_mem[1] = win_mem[4];
		win_mem[2] = win_mem[5];
		win_mem[3] = up2;
		win_mem[4] = up1;
		win_mem[5] = p;
		line_mem[pos_col] = up1;
		line_mem[c3m_pkg::IMAGE_WIDTH + pos_col] = p;
		pos_col++;
		if (pos_col == c3m_pkg::IMAGE_WIDTH) begin
			pos_col = 0;
			pos_row = (pos_row == c3m_pkg::IMAGE_HEIGHT - 1) ? 0 : pos_row + 1;
		end
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// caller lowers cfg_valid after the last write
	task automatic write_reg(input logic [c3m_pkg::CFG_IDX_W-1:0] idx,
			input logic [c3m_pkg::CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			c3m_pkg::REG_COEF_TOP: k_top = data;
			c3m_pkg::REG_COEF_MID: k_mid = data;
			c3m_pkg::REG_COEF_BOT: k_bot = data;
			c3m_pkg::REG_MODULUS:  k_mod = data[c3m_pkg::MOD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_kernel(input logic [c3m_pkg::COEF_W-1:0] top,
			input logic [c3m_pkg::COEF_W-1:0] mid, input logic [c3m_pkg::COEF_W-1:0] bot,
			input logic [c3m_pkg::MOD_W-1:0] modulus);
		logic [c3m_pkg::CFG_DAT_W-1:0] junk;
		junk = $urandom;
		write_reg(c3m_pkg::REG_COEF_TOP, top);
		write_reg(c3m_pkg::REG_COEF_MID, mid);
		write_reg(c3m_pkg::REG_COEF_BOT, bot);
		write_reg(c3m_pkg::REG_MODULUS, {junk[c3m_pkg::CFG_DAT_W-1:c3m_pkg::MOD_W], modulus});
		cfg_valid <= 1'b0;
		cfg_phases++;
	endtask

	// stop sending, let every expected result arrive, then let the tail settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (wrapped_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [c3m_pkg::PIX_W-1:0] p, input int fixed_out);
		int gap;
		gap = lazy_sides ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= p;
		do @(posedge clk); while (in_stall !== 1'b0);
		filter_pixel(p, fixed_out);
		pixels_sent++;
	endtask

	function automatic logic [c3m_pkg::COEF_W-1:0] pick_coefs();
		case ($urandom_range(0, 4))
			0: return 24'h7F7F7F;
			1: return 24'h808080;
			2: return '0;
			default: return c3m_pkg::COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [c3m_pkg::MOD_W-1:0] pick_modulus();
		case ($urandom_range(0, 5))
			0: return 9'd1;
			1: return 9'd256;
			2: return 9'd0;
			3: return c3m_pkg::MOD_W'($urandom_range(257, 511));
			default: return c3m_pkg::MOD_W'($urandom_range(2, 255));
		endcase
	endfunction

	function automatic logic [c3m_pkg::PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return c3m_pkg::PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : result_sink
		int          hold;
		wrapped_px_t want;
		@(posedge arst_n);
		forever begin
			hold = lazy_sides ? $urandom_range(0, 3) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			results_seen++;
			if (wrapped_due.size() == 0) begin
				flag_mismatch("unexpected result, filtered", filtered, -1);
			end else begin
				want = wrapped_due.pop_front();
				if (filtered !== want.filtered)
					flag_mismatch("filtered", filtered, want.filtered);
				if (frame_last !== want.frame_last)
					flag_mismatch("frame_last", frame_last, want.frame_last);
			end
		end
	end

	initial begin : pixel_source
		int span;
		for (int i = 0; i < 2 * c3m_pkg::IMAGE_WIDTH; i++)
			line_mem[i] = '0;
		for (int i = 0; i < 6; i++)
			win_mem[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (fill_spans[i]) begin
			if (fill_spans[i].write_cfg) begin
				wait_drained();
				set_kernel(fill_spans[i].top, fill_spans[i].mid, fill_spans[i].bot,
					fill_spans[i].modulus);
			end
			repeat (fill_spans[i].count)
				send_pixel(fill_spans[i].fill, fill_spans[i].fixed_out);
		end

		while (pixels_sent < TOTAL_PIXELS) begin
			wait_drained();
			set_kernel(pick_coefs(), pick_coefs(), pick_coefs(), pick_modulus());
			lazy_sides = ($urandom_range(0, 3) != 0);
			span = $urandom_range(60, 400);
			if (span > TOTAL_PIXELS - pixels_sent)
				span = TOTAL_PIXELS - pixels_sent;
			repeat (span)
				send_pixel(pick_pixel(), NO_FIXED);
		end
		wait_drained();

		$display("sent %0d pixels under %0d kernel settings, crossing %0d frame ends",
			pixels_sent, cfg_phases, frame_ends);
		$display("checked %0d results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && wrapped_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/c3m_pkg.sv
rtl/c3m_mod_unit.sv
rtl/conv3x3_modulo_wrap.sv
rtl/c3m_checker.sv
sim/tb_top.sv
